[rtl/core/chip8_instruction_core_unit_defines.svh]
// ----------------------------------------------------------------------------
// chip8 instruction core assertion macros
// clocked property checks, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef CHIP8_INSTRUCTION_CORE_UNIT_DEFINES_SVH
`define CHIP8_INSTRUCTION_CORE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define C8IC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);
`define C8IC_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error(msg);
`else
`define C8IC_ASSERT(lbl, clk, rstn, prop, msg)
`define C8IC_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

[rtl/core/c8ic_pkg.sv]
// ----------------------------------------------------------------------------
// chip8 instruction core package
// shared widths, opcode codes, status codes and result structs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package c8ic_pkg;

    localparam int ADDR_W            = 12;
    localparam int MEM_BYTES         = 1 << ADDR_W;
    localparam int STACK_DEPTH_DEF   = 16;
    localparam int IN_DATA_W         = 24;
    localparam int OUT_DATA_W        = 64;
    localparam int RESULT_W          = 58;

    localparam logic [ADDR_W-1:0] LOAD_BASE = 12'h200;
    localparam logic [15:0]       OP_CLEAR  = 16'h00E0;
    localparam logic [15:0]       OP_RETURN = 16'h00EE;

    localparam logic [3:0] NIB_SYS  = 4'h0;
    localparam logic [3:0] NIB_JP   = 4'h1;
    localparam logic [3:0] NIB_CALL = 4'h2;
    localparam logic [3:0] NIB_SE   = 4'h3;
    localparam logic [3:0] NIB_SNE  = 4'h4;
    localparam logic [3:0] NIB_SER  = 4'h5;
    localparam logic [3:0] NIB_LD   = 4'h6;
    localparam logic [3:0] NIB_ADD  = 4'h7;
    localparam logic [3:0] NIB_ALU  = 4'h8;
    localparam logic [3:0] NIB_LDI  = 4'hA;
    localparam logic [3:0] NIB_DRW  = 4'hD;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_UNK = 2'd1,
        ST_OVF = 2'd2,
        ST_UNF = 2'd3
    } t_status;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] pc;
        logic [ADDR_W-1:0] index;
        logic              index_we;
        logic              reg_we;
        logic [7:0]        reg_val;
        logic              push;
        logic              pop;
        logic              draw;
        logic              clear;
        logic              skip;
    } t_exec;

    // first member sits in the top bits
    typedef struct packed {
        logic              skipped;
        logic              clear_screen;
        logic              draw_request;
        logic [7:0]        reg_value;
        logic [3:0]        reg_number;
        logic              reg_written;
        logic [ADDR_W-1:0] index_value;
        logic [ADDR_W-1:0] next_pc;
        logic [15:0]       executed_opcode;
        t_status           status;
    } t_result;

endpackage

[rtl/core/chip8_instruction_core_unit.sv]
// ----------------------------------------------------------------------------
// chip8 instruction core unit
// After reset the block clears program memory and the registers and takes
// no word meanwhile. A program byte write is written to memory as it is
// taken. An execute first reads both opcode bytes from program memory as
// the word is taken, reads the general registers in S_FETCH and completes
// the step in S_EXEC once the output is free; the next word is taken in
// that same cycle, so its fetch overlaps the completing step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chip8_instruction_core_unit_defines.svh"

module chip8_instruction_core_unit
    import c8ic_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // load_offset, load_byte
    input  logic                  s_axis_tuser,   // req_type
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status, executed_opcode, next_pc, index_value, reg_written, reg_number,
    // reg_value, draw_request, clear_screen, skipped
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int SW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_WRES
    } t_state;

    t_state            r_state;
    logic [ADDR_W-1:0] r_clr;
    logic [ADDR_W-1:0] r_pc;
    logic [ADDR_W-1:0] r_index;
    logic [SP_W-1:0]   r_sp;
    logic [15:0]       r_op;
    logic              r_out_valid;
    t_result           r_out;
    logic [ADDR_W-1:0] r_stack [STACK_DEPTH];

    logic              w_in_acc;
    logic              w_out_free;
    logic              w_out_load;
    logic              w_done;
    logic [ADDR_W-1:0] w_fetch_pc;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [7:0]        w_mem_rd_a;
    logic [7:0]        w_mem_rd_b;
    logic              w_mem_we;
    logic [ADDR_W-1:0] w_mem_waddr;
    logic [7:0]        w_mem_wdata;
    logic [7:0]        w_vx;
    logic [7:0]        w_vy;
    logic              w_rf_we;
    logic [3:0]        w_rf_waddr;
    logic [7:0]        w_rf_wdata;
    logic [SP_W-1:0]   w_sp_dec;
    t_exec             w_res;
    t_result           w_exec_out;
    t_result           w_wr_out;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = ((r_state == S_IDLE) || (r_state == S_EXEC)) && w_out_free;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_done        = (r_state == S_EXEC) && w_out_free;
    assign w_out_load    = ((r_state == S_IDLE) && w_in_acc && !s_axis_tuser) || w_done
                           || ((r_state == S_WRES) && w_out_free);
    assign w_fetch_pc    = (r_state == S_EXEC) ? w_res.pc : r_pc;
    assign w_wr_addr     = LOAD_BASE + s_axis_tdata[ADDR_W-1:0];
    assign w_sp_dec      = r_sp - SP_W'(1);

    // clearing pass owns both write ports until it ends
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_mem_we    = 1'b1;
            w_mem_waddr = r_clr;
            w_mem_wdata = '0;
            w_rf_we     = 1'b1;
            w_rf_waddr  = r_clr[3:0];
            w_rf_wdata  = '0;
        end else begin
            w_mem_we    = w_in_acc && !s_axis_tuser;
            w_mem_waddr = w_wr_addr;
            w_mem_wdata = s_axis_tdata[ADDR_W +: 8];
            w_rf_we     = w_done && w_res.reg_we;
            w_rf_waddr  = r_op[11:8];
            w_rf_wdata  = w_res.reg_val;
        end
    end

    c8ic_prog_mem u_prog_mem (
        .i_clk     (i_clk),
        .i_we      (w_mem_we),
        .i_waddr   (w_mem_waddr),
        .i_wdata   (w_mem_wdata),
        .i_re      (w_in_acc && s_axis_tuser),
        .i_raddr_a (w_fetch_pc),
        .i_raddr_b (w_fetch_pc + ADDR_W'(1)),
        .o_rdata_a (w_mem_rd_a),
        .o_rdata_b (w_mem_rd_b)
    );

    c8ic_reg_file u_reg_file (
        .i_clk     (i_clk),
        .i_we      (w_rf_we),
        .i_waddr   (w_rf_waddr),
        .i_wdata   (w_rf_wdata),
        .i_re      (r_state == S_FETCH),
        .i_raddr_a (w_mem_rd_a[3:0]),
        .i_raddr_b (w_mem_rd_b[7:4]),
        .o_rdata_a (w_vx),
        .o_rdata_b (w_vy)
    );

    c8ic_exec u_exec (
        .i_op        (r_op),
        .i_vx        (w_vx),
        .i_vy        (w_vy),
        .i_pc        (r_pc),
        .i_index     (r_index),
        .i_sp_empty  (r_sp == '0),
        .i_sp_full   (r_sp >= SP_W'(STACK_DEPTH)),
        .i_stack_top (r_stack[w_sp_dec[SW-1:0]]),
        .o_res       (w_res)
    );

    always_comb begin
        w_exec_out                 = '0;
        w_exec_out.status          = w_res.status;
        w_exec_out.executed_opcode = r_op;
        w_exec_out.next_pc         = w_res.pc;
        w_exec_out.index_value     = w_res.index;
        w_exec_out.reg_written     = w_res.reg_we;
        w_exec_out.reg_number      = w_res.reg_we ? r_op[11:8] : 4'd0;
        w_exec_out.reg_value       = w_res.reg_we ? w_res.reg_val : 8'd0;
        w_exec_out.draw_request    = w_res.draw;
        w_exec_out.clear_screen    = w_res.clear;
        w_exec_out.skipped         = w_res.skip;
    end

    always_comb begin
        w_wr_out             = '0;
        w_wr_out.status      = ST_OK;
        w_wr_out.next_pc     = r_pc;
        w_wr_out.index_value = r_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pc        <= LOAD_BASE;
            r_index     <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_out_load || (r_out_valid && !m_axis_tready);
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (s_axis_tuser) begin
                            r_state <= S_FETCH;
                        end else begin
                            r_out <= w_wr_out;
                        end
                    end
                end
                S_FETCH: begin
                    r_op    <= {w_mem_rd_a, w_mem_rd_b};
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (w_out_free) begin
                        r_out   <= w_exec_out;
                        r_pc    <= w_res.pc;
                        r_index <= w_res.index;
                        if (w_res.push) begin
                            r_sp <= r_sp + SP_W'(1);
                        end else if (w_res.pop) begin
                            r_sp <= w_sp_dec;
                        end
                        if (w_in_acc) begin
                            r_state <= s_axis_tuser ? S_FETCH : S_WRES;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_WRES: begin
                    if (w_out_free) begin
                        r_out   <= w_wr_out;
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_res.push) begin
            r_stack[r_sp[SW-1:0]] <= r_pc + ADDR_W'(2);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_W - RESULT_W)'(0), r_out};

    `C8IC_ASSERT(a_sp_range, i_clk, i_rst_n, r_sp <= SP_W'(STACK_DEPTH), "stack level out of range")
    `C8IC_ASSERT_NEVER(a_no_accept_in_clear, i_clk, i_rst_n, (r_state == S_CLEAR) && s_axis_tready, "word taken during clearing pass")
    `C8IC_ASSERT(a_fetch_to_exec, i_clk, i_rst_n, (r_state == S_FETCH) |=> (r_state == S_EXEC), "fetch not followed by execute")
    `C8IC_ASSERT(a_fault_holds_pc, i_clk, i_rst_n, (w_done && (w_res.status == ST_OVF || w_res.status == ST_UNF)) |=> (r_pc == $past(r_pc)), "stack fault moved pc")

endmodule

[rtl/core/c8ic_prog_mem.sv]
// ----------------------------------------------------------------------------
// chip8 program memory
// byte memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c8ic_prog_mem
    import c8ic_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [7:0]        o_rdata_a,
    output logic [7:0]        o_rdata_b
);

    logic [7:0] r_mem [MEM_BYTES];
    logic [7:0] r_rd_a;
    logic [7:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_a <= r_mem[i_raddr_a];
            r_rd_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

[rtl/core/c8ic_reg_file.sv]
// ----------------------------------------------------------------------------
// chip8 general register file
// sixteen byte registers, one write port and two registered read ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c8ic_reg_file
    import c8ic_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_we,
    input  logic [3:0] i_waddr,
    input  logic [7:0] i_wdata,
    input  logic       i_re,
    input  logic [3:0] i_raddr_a,
    input  logic [3:0] i_raddr_b,
    output logic [7:0] o_rdata_a,
    output logic [7:0] o_rdata_b
);

    logic [7:0] r_mem [16];
    logic [7:0] r_rd_a;
    logic [7:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_a <= r_mem[i_raddr_a];
            r_rd_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

[rtl/core/c8ic_exec.sv]
// ----------------------------------------------------------------------------
// chip8 execute unit
// decodes one opcode and forms next pc, index, register and stack actions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module c8ic_exec
    import c8ic_pkg::*;
(
    input  logic [15:0]       i_op,
    input  logic [7:0]        i_vx,
    input  logic [7:0]        i_vy,
    input  logic [ADDR_W-1:0] i_pc,
    input  logic [ADDR_W-1:0] i_index,
    input  logic              i_sp_empty,
    input  logic              i_sp_full,
    input  logic [ADDR_W-1:0] i_stack_top,
    output t_exec             o_res
);

    logic [3:0]        w_nib;
    logic [7:0]        w_nn;
    logic [ADDR_W-1:0] w_nnn;
    logic [ADDR_W-1:0] w_pc_adv;
    logic              w_take;

    assign w_nib    = i_op[15:12];
    assign w_nn     = i_op[7:0];
    assign w_nnn    = i_op[ADDR_W-1:0];
    assign w_pc_adv = i_pc + ADDR_W'(2);

    always_comb begin
        o_res          = '0;
        o_res.status   = ST_OK;
        o_res.pc       = w_pc_adv;
        o_res.index    = i_index;
        w_take         = 1'b0;
        unique case (w_nib)
            NIB_SYS: begin
                if (i_op == OP_CLEAR) begin
                    o_res.draw  = 1'b1;
                    o_res.clear = 1'b1;
                end else if (i_op == OP_RETURN) begin
                    if (i_sp_empty) begin
                        o_res.status = ST_UNF;
                        o_res.pc     = i_pc;
                    end else begin
                        o_res.pop = 1'b1;
                        o_res.pc  = i_stack_top;
                    end
                end
            end
            NIB_JP: begin
                o_res.pc = w_nnn;
            end
            NIB_CALL: begin
                if (i_sp_full) begin
                    o_res.status = ST_OVF;
                    o_res.pc     = i_pc;
                end else begin
                    o_res.push = 1'b1;
                    o_res.pc   = w_nnn;
                end
            end
            NIB_SE:  w_take = (i_vx == w_nn);
            NIB_SNE: w_take = (i_vx != w_nn);
            NIB_SER: w_take = (i_vx == i_vy);
            NIB_LD: begin
                o_res.reg_we  = 1'b1;
                o_res.reg_val = w_nn;
            end
            NIB_ADD: begin
                o_res.reg_we  = 1'b1;
                o_res.reg_val = i_vx + w_nn;
            end
            NIB_ALU: begin
                unique case (i_op[3:0])
                    ALU_MOV: begin
                        o_res.reg_we  = 1'b1;
                        o_res.reg_val = i_vy;
                    end
                    ALU_OR: begin
                        o_res.reg_we  = 1'b1;
                        o_res.reg_val = i_vx | i_vy;
                    end
                    ALU_AND: begin
                        o_res.reg_we  = 1'b1;
                        o_res.reg_val = i_vx & i_vy;
                    end
                    ALU_XOR: begin
                        o_res.reg_we  = 1'b1;
                        o_res.reg_val = i_vx ^ i_vy;
                    end
                    default: begin
                        o_res.reg_we = 1'b0;
                    end
                endcase
            end
            NIB_LDI: begin
                o_res.index_we = 1'b1;
                o_res.index    = w_nnn;
            end
            NIB_DRW: begin
                o_res.draw = 1'b1;
            end
            default: begin
                o_res.status = ST_UNK;
            end
        endcase
        if (w_take) begin
            o_res.pc   = w_pc_adv + ADDR_W'(2);
            o_res.skip = 1'b1;
        end
    end

endmodule
